>>> hw/rtl/ssfg_pkg.sv
package ssfg_pkg;

    // Command codes carried by an input request
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_BLANK = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_SCANNED = 2'd1;
    localparam int CFG_DATA_W = 4;

    // Controller register addresses
    localparam logic [7:0] REG_DECODE    = 8'h09;
    localparam logic [7:0] REG_INTENSITY = 8'h0a;
    localparam logic [7:0] REG_SCANLIM   = 8'h0b;
    localparam logic [7:0] REG_SHUTDOWN  = 8'h0c;
    localparam logic [7:0] REG_TEST      = 8'h0f;

    // Burst step counter and the init header steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SCANLIM   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TEST      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_INTENSITY = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SHUTDOWN  = 4'd4;
    localparam logic [STEP_W-1:0] INIT_HDR_LEN   = 4'd5;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] character;
        logic [2:0] digit_position;
    } in_item_t;

    typedef struct packed {
        logic [15:0] frame;
        logic        last_frame;
    } out_item_t;

    typedef struct packed {
        logic [3:0] brightness;
        logic [2:0] digits_scanned;
    } cfg_t;

    // Segment pattern for bits 6..0 of a character; lower case folds to upper
    function automatic logic [7:0] seg_pattern(input logic [6:0] code);
        logic [6:0] c;
        logic [7:0] seg;
        c = (code > 7'h5f) ? (code - 7'h20) : code;
        case (c)
            7'h30: seg = 8'h7e;  // 0
            7'h31: seg = 8'h30;
            7'h32: seg = 8'h6d;
            7'h33: seg = 8'h79;
            7'h34: seg = 8'h33;
            7'h35: seg = 8'h5b;
            7'h36: seg = 8'h5f;
            7'h37: seg = 8'h70;
            7'h38: seg = 8'h7f;
            7'h39: seg = 8'h7b;  // 9
            7'h20: seg = 8'h00;  // space
            7'h41: seg = 8'h77;  // A
            7'h42: seg = 8'h1f;
            7'h43: seg = 8'h4e;
            7'h44: seg = 8'h3d;
            7'h45: seg = 8'h4f;
            7'h46: seg = 8'h47;
            7'h48: seg = 8'h17;  // H
            7'h49: seg = 8'h06;
            7'h4a: seg = 8'h38;
            7'h4c: seg = 8'h0e;  // L
            7'h4f: seg = 8'h7e;  // O
            7'h50: seg = 8'h67;
            7'h53: seg = 8'h5b;  // S
            7'h54: seg = 8'h0f;
            7'h55: seg = 8'h3e;
            7'h2d: seg = 8'h01;  // minus
            7'h5f: seg = 8'h08;  // underscore
            7'h2e: seg = 8'h80;  // period
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> hw/rtl/ssfg_frame_sel.sv
module ssfg_frame_sel import ssfg_pkg::*; #(
    parameter int NUM_DIGITS = 8
) (
    input  in_item_t           item,
    input  logic [STEP_W-1:0]  step,
    input  cfg_t               cfg,
    output out_item_t          result
);

    localparam logic [3:0] NumDigits = 4'(NUM_DIGITS);
    localparam logic [3:0] LastDigit = 4'(NUM_DIGITS - 1);

    logic [3:0] blank_k;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;

    always_comb begin
        blank_k = (item.cmd == CMD_INIT) ? (step - INIT_HDR_LEN) : step;
        addr    = 8'h00;
        data    = 8'h00;
        last    = 1'b1;
        case (item.cmd)
            CMD_INIT: begin
                last = 1'b0;
                case (step)
                    STEP_SCANLIM: begin
                        addr = REG_SCANLIM;
                        data = {5'b0, cfg.digits_scanned};
                    end
                    STEP_DECODE: begin
                        addr = REG_DECODE;
                    end
                    STEP_TEST: begin
                        addr = REG_TEST;
                    end
                    STEP_INTENSITY: begin
                        addr = REG_INTENSITY;
                        data = {4'b0, cfg.brightness};
                    end
                    STEP_SHUTDOWN: begin
                        addr = REG_SHUTDOWN;
                        data = 8'h01;
                    end
                    default: begin
                        // blank digits, highest register first
                        addr = {4'b0, NumDigits - blank_k};
                        last = (blank_k == LastDigit);
                    end
                endcase
            end
            CMD_BLANK: begin
                addr = {4'b0, NumDigits - blank_k};
                last = (blank_k == LastDigit);
            end
            CMD_CHAR: begin
                addr = {4'b0, NumDigits - {1'b0, item.digit_position}};
                data = seg_pattern(item.character[6:0]) | {item.character[7], 7'b0};
            end
            default: begin
                addr = 8'h00;
            end
        endcase
        result.frame      = {addr, data};
        result.last_frame = last;
    end

endmodule

>>> hw/rtl/seven_segment_frame_generator.sv
// Seven-segment frame generator: turns display commands into 16-bit register
// frames (address in the high byte, data in the low byte) for a serializer.
// Input channel s_*: one request holds cmd, character and digit_position.
//   init  -> scan limit, decode off, test off, intensity, shutdown=1,
//            then NUM_DIGITS blank digits (NUM_DIGITS+5 frames)
//   char  -> one frame to digit register NUM_DIGITS-position (none if the
//            position is out of range)
//   blank -> NUM_DIGITS frames, register NUM_DIGITS down to 1
//   code 3 produces no frames.
// Output channel m_*: one frame per transfer, last_frame marks the end of a
// burst. The accepted request is registered, then each frame is registered
// in the output register. Frames follow one per cycle while m_ready is high;
// a request makes 13 frames for init, 8 for blank, 1 for char, at
// NUM_DIGITS = 8. The next request is taken in the cycle the last frame of
// the current burst is issued, so single-frame requests stream at one per
// cycle while the receiver is ready.
// A stalled receiver holds the output register; the sequencer holds with it.
// Configuration (cfg_*) is always ready; write only while idle.
// Reset clears the burst and output valid and loads brightness 1, scan limit 7.
module seven_segment_frame_generator import ssfg_pkg::*; #(
    parameter int NUM_DIGITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    // frame channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] NumDigits = 4'(NUM_DIGITS);

    in_item_t          item_reg, item_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    cfg_t              cfg_reg, cfg_next;

    out_item_t         frame_cur;
    logic              advance;
    logic              s_accept;
    logic              has_frames;

    // Frame for the current step of the burst
    ssfg_frame_sel #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_frame_sel (
        .item   (item_reg),
        .step   (step_reg),
        .cfg    (cfg_reg),
        .result (frame_cur)
    );

    always_comb begin
        // advance the burst whenever the output register is free or draining
        advance  = busy_reg && (!m_valid_reg || m_ready);
        s_ready  = !busy_reg || (advance && frame_cur.last_frame);
        s_accept = s_valid && s_ready;

        has_frames = (s_data.cmd == CMD_INIT) || (s_data.cmd == CMD_BLANK) ||
                     ((s_data.cmd == CMD_CHAR) &&
                      ({1'b0, s_data.digit_position} < NumDigits));

        item_next = item_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (advance) begin
            step_next = step_reg + 1'b1;
            if (frame_cur.last_frame) begin
                busy_next = 1'b0;
            end
        end
        // load a new request; drop ones that produce no frames
        if (s_accept) begin
            item_next = s_data;
            step_next = '0;
            busy_next = has_frames;
        end

        // output register: load on advance, clear when taken, else hold
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = frame_cur;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_BRIGHTNESS:     cfg_next.brightness     = cfg_data[3:0];
                CFG_DIGITS_SCANNED: cfg_next.digits_scanned = cfg_data[2:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg               <= 1'b0;
            m_valid_reg            <= 1'b0;
            cfg_reg.brightness     <= 4'd1;
            cfg_reg.digits_scanned <= 3'd7;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
